// ----- src/hcm_pkg.sv -----
// Shared types, register codes and Sobel kernels for the Harris corner mask.
// No dependencies; all files but hcm_ram use it, hcm_checker also by import.
package hcm_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int CFG_DW = 48;
  localparam int CFG_IW = 4;

  localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 4'd1;
  localparam logic [CFG_IW-1:0] REG_K_Q16        = 4'd2;
  localparam logic [CFG_IW-1:0] REG_THRESHOLD    = 4'd3;

  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [10:0] HEIGHT_RST = 11'd480;
  localparam logic [15:0] K_RST      = 16'd3277;
  localparam logic [47:0] THR_RST    = 48'd409600;

  localparam logic [7:0] MARK_CORNER = 8'd0;
  localparam logic [7:0] MARK_PLAIN  = 8'd255;

  typedef struct packed {
    logic [7:0] pixel;
    logic       drain;
  } pix_t;

  typedef struct packed {
    logic [7:0] mark;
    logic       is_corner;
    logic       last;
  } res_t;

  // one entry of the product line store
  typedef struct packed {
    logic        [19:0] xx;
    logic        [19:0] yy;
    logic signed [20:0] xy;
  } prod_t;

  localparam int PROD_W = 61;

  typedef logic signed [2:0] coef_t;

  localparam coef_t SOBEL_X [9] = '{-3'sd1, 3'sd0, 3'sd1, -3'sd2, 3'sd0, 3'sd2,
                                    -3'sd1, 3'sd0, 3'sd1};
  localparam coef_t SOBEL_Y [9] = '{-3'sd1, -3'sd2, -3'sd1, 3'sd0, 3'sd0, 3'sd0,
                                    3'sd1, 3'sd2, 3'sd1};

  typedef struct packed {
    logic       take;
    logic       grd_rd;
    logic       win_rd;
    logic [4:0] tap_idx;
    logic       prod_we;
    logic       mul1;
    logic       mul2;
    logic       mul3;
    logic       mul4;
    logic       emit;
    logic       advance;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic emit_en;
    logic out_free;
  } sts_t;

endpackage

// ----- src/hcm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/hcm_ctrl.sv -----
// Sequencer for the corner mask: steps the datapath through gradient taps,
// product write, window taps, response multiplies and result hand-off. Uses hcm_pkg.
module hcm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          pix_valid,
  input  hcm_pkg::sts_t sts,
  output hcm_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GRD   = 4'd1;
  localparam logic [3:0] S_GLAST = 4'd2;
  localparam logic [3:0] S_PROD  = 4'd3;
  localparam logic [3:0] S_WIN   = 4'd4;
  localparam logic [3:0] S_WLAST = 4'd5;
  localparam logic [3:0] S_MUL1  = 4'd6;
  localparam logic [3:0] S_MUL2  = 4'd7;
  localparam logic [3:0] S_MUL3  = 4'd8;
  localparam logic [3:0] S_MUL4  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0] state, state_next;
  logic [4:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    cmd.tap_idx = cnt;
    case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        cnt_next = '0;
        if (pix_valid && !sts.drop) begin
          state_next = S_GRD;
        end
      end
      S_GRD: begin
        cmd.grd_rd = 1'b1;
        cnt_next   = cnt + 5'd1;
        if (cnt == 5'd8) begin
          state_next = S_GLAST;
        end
      end
      S_GLAST: state_next = S_PROD;
      S_PROD: begin
        cmd.prod_we = 1'b1;
        cnt_next    = '0;
        if (sts.emit_en) begin
          state_next = S_WIN;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_WIN: begin
        cmd.win_rd = 1'b1;
        cnt_next   = cnt + 5'd1;
        if (cnt == 5'd24) begin
          state_next = S_WLAST;
        end
      end
      S_WLAST: state_next = S_MUL1;
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3   = 1'b1;
        state_next = S_MUL4;
      end
      S_MUL4: begin
        cmd.mul4   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.advance = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- src/hcm_dp.sv -----
// Datapath: registers, raster counters, pixel and product line stores,
// gradient and window accumulators, response multiplies. Uses hcm_pkg, hcm_ram.
module hcm_dp #(
  parameter int MAX_WIDTH  = hcm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hcm_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [hcm_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [hcm_pkg::CFG_DW-1:0]   cfg_data,
  input  logic                         pix_valid,
  input  hcm_pkg::pix_t                pix_data,
  input  logic                         res_stall,
  output logic                         res_valid,
  output hcm_pkg::res_t                res_data,
  input  hcm_pkg::cmd_t                cmd,
  output hcm_pkg::sts_t                sts
);

  localparam int PD  = 2 * MAX_WIDTH + 3;
  localparam int QD  = 4 * MAX_WIDTH + 5;
  localparam int PAW = $clog2(PD);
  localparam int QAW = $clog2(QD);
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 5);

  // configuration
  logic [10:0] image_width, image_height;
  logic [15:0] k_q16;
  logic [47:0] corner_threshold;
  logic        restart;

  assign restart = cfg_we && (cfg_index == hcm_pkg::REG_IMAGE_WIDTH ||
                              cfg_index == hcm_pkg::REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= hcm_pkg::WIDTH_RST;
      image_height     <= hcm_pkg::HEIGHT_RST;
      k_q16            <= hcm_pkg::K_RST;
      corner_threshold <= hcm_pkg::THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hcm_pkg::REG_IMAGE_WIDTH:  image_width      <= cfg_data[10:0];
        hcm_pkg::REG_IMAGE_HEIGHT: image_height     <= cfg_data[10:0];
        hcm_pkg::REG_K_Q16:        k_q16            <= cfg_data[15:0];
        hcm_pkg::REG_THRESHOLD:    corner_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [CW-1:0] w;
  logic [RW-1:0] h;

  always_comb begin
    if (32'(image_width) < 32'd5) begin
      w = CW'(5);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(image_width);
    end
    if (32'(image_height) < 32'd5) begin
      h = RW'(5);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h = RW'(MAX_HEIGHT);
    end else begin
      h = RW'(image_height);
    end
  end

  // raster counters: input position and output position
  logic [RW-1:0]  row, orow, grow;
  logic [CW-1:0]  col, ocol, gcol;
  logic [PAW-1:0] pix_ptr;
  logic [QAW-1:0] prod_ptr;
  logic           in_frame, gvalid, grad_int, out_int, olast, accept;

  assign in_frame = row < h;
  assign accept   = pix_valid && cmd.take;
  assign gvalid   = (row >= RW'(2)) || (row == RW'(1) && col != '0);
  assign grow     = (col != '0) ? row - RW'(1) : row - RW'(2);
  assign gcol     = (col != '0) ? col - CW'(1) : w - CW'(1);
  assign grad_int = gvalid && grow >= RW'(1) && (grow + RW'(2)) <= h &&
                    gcol >= CW'(1) && (CW'(gcol) + CW'(2)) <= w;
  assign out_int  = orow >= RW'(2) && (orow + RW'(3)) <= h &&
                    ocol >= CW'(2) && (ocol + CW'(3)) <= w;
  assign olast    = (orow == h - RW'(1)) && (ocol == w - CW'(1));

  assign sts.drop     = in_frame && pix_data.drain;
  assign sts.emit_en  = ((row >= RW'(4)) || (row == RW'(3) && col >= CW'(3))) && (orow < h);
  assign sts.out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      col      <= '0;
      orow     <= '0;
      ocol     <= '0;
      pix_ptr  <= '0;
      prod_ptr <= '0;
    end else if (restart) begin
      row  <= '0;
      col  <= '0;
      orow <= '0;
      ocol <= '0;
    end else if (cmd.advance) begin
      pix_ptr  <= (32'(pix_ptr) == PD - 1) ? '0 : pix_ptr + PAW'(1);
      prod_ptr <= (32'(prod_ptr) == QD - 1) ? '0 : prod_ptr + QAW'(1);
      if (cmd.emit && olast) begin
        row  <= '0;
        col  <= '0;
        orow <= '0;
        ocol <= '0;
      end else begin
        if (col == w - CW'(1)) begin
          col <= '0;
          row <= row + RW'(1);
        end else begin
          col <= col + CW'(1);
        end
        if (cmd.emit) begin
          if (ocol == w - CW'(1)) begin
            ocol <= '0;
            orow <= orow + RW'(1);
          end else begin
            ocol <= ocol + CW'(1);
          end
        end
      end
    end
  end

  // pixel line store
  logic [PAW-1:0] pa;
  logic [PAW:0]   pa_init, pa_sum;
  logic [7:0]     pix_rd;
  logic [7:0]     pix_wr;

  assign pix_wr  = in_frame ? pix_data.pixel : 8'd0;
  assign pa_init = (PAW+1)'(pix_ptr) + (PAW+1)'(PD) - (PAW+1)'({w, 1'b0}) - (PAW+1)'(2);
  assign pa_sum  = (PAW+1)'(pa) + ((cmd.tap_idx == 5'd2 || cmd.tap_idx == 5'd5) ?
                   (PAW+1)'(w) - (PAW+1)'(2) : (PAW+1)'(1));

  always_ff @(posedge clk) begin
    if (accept) begin
      pa <= (pa_init >= (PAW+1)'(PD)) ? PAW'(pa_init - (PAW+1)'(PD)) : PAW'(pa_init);
    end else if (cmd.grd_rd) begin
      pa <= (pa_sum >= (PAW+1)'(PD)) ? PAW'(pa_sum - (PAW+1)'(PD)) : PAW'(pa_sum);
    end
  end

  hcm_ram #(.WIDTH(8), .DEPTH(PD)) u_pix_ram (
    .clk   (clk),
    .we    (accept && !sts.drop),
    .waddr (pix_ptr),
    .wdata (pix_wr),
    .raddr (pa),
    .rdata (pix_rd)
  );

  // gradient accumulation, each tap added in the cycle after its read
  logic               g_acc, w_acc;
  logic [4:0]         idx_d;
  logic signed [10:0] gx, gy, vx, tx, ty;

  assign vx = {3'b000, pix_rd};
  assign tx = 11'(hcm_pkg::SOBEL_X[idx_d[3:0]]) * vx;
  assign ty = 11'(hcm_pkg::SOBEL_Y[idx_d[3:0]]) * vx;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_acc <= 1'b0;
      w_acc <= 1'b0;
    end else begin
      g_acc <= cmd.grd_rd;
      w_acc <= cmd.win_rd;
    end
  end

  always_ff @(posedge clk) begin
    idx_d <= cmd.tap_idx;
    if (accept) begin
      gx <= '0;
      gy <= '0;
    end else if (g_acc && grad_int) begin
      gx <= gx + tx;
      gy <= gy + ty;
    end
  end

  // product line store
  hcm_pkg::prod_t pw, pr;
  logic signed [21:0] gxx, gyy, gxy;
  logic [QAW-1:0]     qa;
  logic [QAW:0]       qa_init, qa_sum;
  logic [hcm_pkg::PROD_W-1:0] pr_bits;

  assign gxx   = gx * gx;
  assign gyy   = gy * gy;
  assign gxy   = gx * gy;
  assign pw.xx = gxx[19:0];
  assign pw.yy = gyy[19:0];
  assign pw.xy = gxy[20:0];
  assign pr    = hcm_pkg::prod_t'(pr_bits);

  assign qa_init = (QAW+1)'(prod_ptr) + (QAW+1)'(QD) - (QAW+1)'({w, 2'b00}) - (QAW+1)'(4);
  assign qa_sum  = (QAW+1)'(qa) + ((cmd.tap_idx == 5'd4 || cmd.tap_idx == 5'd9 ||
                   cmd.tap_idx == 5'd14 || cmd.tap_idx == 5'd19) ?
                   (QAW+1)'(w) - (QAW+1)'(4) : (QAW+1)'(1));

  always_ff @(posedge clk) begin
    if (cmd.prod_we) begin
      qa <= (qa_init >= (QAW+1)'(QD)) ? QAW'(qa_init - (QAW+1)'(QD)) : QAW'(qa_init);
    end else if (cmd.win_rd) begin
      qa <= (qa_sum >= (QAW+1)'(QD)) ? QAW'(qa_sum - (QAW+1)'(QD)) : QAW'(qa_sum);
    end
  end

  hcm_ram #(.WIDTH(hcm_pkg::PROD_W), .DEPTH(QD)) u_prod_ram (
    .clk   (clk),
    .we    (cmd.prod_we),
    .waddr (prod_ptr),
    .wdata (pw),
    .raddr (qa),
    .rdata (pr_bits)
  );

  // window sums and response
  logic        [24:0] sxx, syy;
  logic signed [25:0] sxy;
  logic signed [51:0] sq_xy;
  logic        [49:0] p_xy, p_xx_yy, det;
  logic        [25:0] s_sum;
  logic        [51:0] t;
  logic        [41:0] kt_lo, kt_hi;
  logic        [68:0] rhs;
  logic               corner;

  assign sq_xy  = sxy * sxy;
  assign corner = out_int && (69'({det, 16'h0000}) > rhs);

  always_ff @(posedge clk) begin
    if (cmd.prod_we) begin
      sxx <= '0;
      syy <= '0;
      sxy <= '0;
    end else if (w_acc && out_int) begin
      sxx <= sxx + 25'(pr.xx);
      syy <= syy + 25'(pr.yy);
      sxy <= sxy + 26'(pr.xy);
    end
    if (cmd.mul1) begin
      p_xx_yy <= sxx * syy;
      p_xy    <= sq_xy[49:0];
      s_sum   <= 26'(sxx) + 26'(syy);
    end
    if (cmd.mul2) begin
      det <= (p_xx_yy > p_xy) ? p_xx_yy - p_xy : '0;
      t   <= s_sum * s_sum;
    end
    if (cmd.mul3) begin
      kt_lo <= t[25:0] * k_q16;
      kt_hi <= t[51:26] * k_q16;
    end
    if (cmd.mul4) begin
      rhs <= 69'({kt_hi, 26'h0}) + 69'(kt_lo) + 69'(corner_threshold);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_data.mark      <= corner ? hcm_pkg::MARK_CORNER : hcm_pkg::MARK_PLAIN;
      res_data.is_corner <= corner;
      res_data.last      <= olast;
    end
  end

endmodule

// ----- src/harris_corner_mask.sv -----
// Top level of the Harris corner mask: sequencer plus datapath.
// Uses hcm_pkg, hcm_ctrl, hcm_dp (which holds two hcm_ram line stores).
//
//  port group  dir  handshake              word
//  pix_*       in   pix_valid/pix_stall    pix_t: pixel, drain
//  res_*       out  res_valid/res_stall    res_t: mark, is_corner, last
//  cfg_*       in   cfg_we                 cfg_index, cfg_data
//
// One word at a time. A word with no result makes 9 reads of the pixel line
// store for the Sobel taps, then the product write. A word with a result
// goes on with 25 product store reads for the 5x5 window and four multiply
// steps, then may wait on res_stall. A drain word inside the frame is taken
// and dropped in the idle state. Reset is synchronous; the line stores are
// not cleared. A stalled result holds in the output register.
module harris_corner_mask #(
  parameter int MAX_WIDTH  = hcm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hcm_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [hcm_pkg::CFG_IW-1:0] cfg_index,
  input  logic [hcm_pkg::CFG_DW-1:0] cfg_data,
  input  logic                       pix_valid,
  output logic                       pix_stall,
  input  hcm_pkg::pix_t              pix_data,
  output logic                       res_valid,
  input  logic                       res_stall,
  output hcm_pkg::res_t              res_data
);

  hcm_pkg::cmd_t cmd;
  hcm_pkg::sts_t sts;

  assign pix_stall = !cmd.take;

  hcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  hcm_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_data  (pix_data),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res_data  (res_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- dv/hcm_checker.sv -----
// Checker for harris_corner_mask: watches config writes and both word channels,
// predicts each result from its own copy of the state and compares. Uses hcm_pkg.
module hcm_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [hcm_pkg::CFG_IW-1:0] cfg_index,
  input  logic [hcm_pkg::CFG_DW-1:0] cfg_data,
  input  logic                       pix_valid,
  input  logic                       pix_stall,
  input  hcm_pkg::pix_t              pix_data,
  input  logic                       res_valid,
  input  logic                       res_stall,
  input  hcm_pkg::res_t              res_data,
  output int                         fails,
  output int                         pending,
  output int                         results,
  output int                         corners
);
  timeunit 1ns;
  timeprecision 1ps;
  import hcm_pkg::*;

  localparam int MAXW   = 1024;
  localparam int MAXH   = 1024;
  localparam int PIX_D  = 2 * MAXW + 3;
  localparam int PROD_D = 4 * MAXW + 5;

  logic [10:0] width_reg, height_reg;
  logic [15:0] k_reg;
  logic [47:0] thr_reg;
  logic [7:0]  line_pix [PIX_D];
  int          grad_xx [PROD_D];
  int          grad_yy [PROD_D];
  int          grad_xy [PROD_D];
  int          pix_wr, prod_wr, row_pos, col_pos, emitted;
  res_t        marks_due [$];

  assign pending = marks_due.size();

  function automatic int clamp_dim(int v, int mx);
    if (v < 5) return 5;
    if (v > mx) return mx;
    return v;
  endfunction

  task automatic restart_frame();
    row_pos = 0;
    col_pos = 0;
    emitted = 0;
  endtask

  task automatic predict_mark(pix_t wd);
    int w, h, total, n, gx, gy, g, gr, gc, d, v, o, orow, ocol;
    longint sxx, syy, sxy, det, t;
    logic [127:0] lhs, rhs;
    bit corner;
    res_t r;
    w = clamp_dim(width_reg, MAXW);
    h = clamp_dim(height_reg, MAXH);
    total = w * h;
    n = row_pos * w + col_pos;
    gx = 0;
    gy = 0;
    if (n < total && wd.drain) return;
    line_pix[pix_wr] = (n < total) ? wd.pixel : 8'd0;
    if (n >= w + 1) begin
      g = n - w - 1;
      gr = g / w;
      gc = g % w;
      if (gr >= 1 && gr + 2 <= h && gc >= 1 && gc + 2 <= w) begin
        for (int a = -1; a <= 1; a++) begin
          for (int b = -1; b <= 1; b++) begin
            d = w + 1 - a * w - b;
            v = line_pix[(pix_wr + PIX_D - d) % PIX_D];
            // sobel taps: center row/column weighted by two
            gx += b * ((a == 0) ? 2 : 1) * v;
            gy += a * ((b == 0) ? 2 : 1) * v;
          end
        end
      end
    end
    grad_xx[prod_wr] = gx * gx;
    grad_yy[prod_wr] = gy * gy;
    grad_xy[prod_wr] = gx * gy;
    if (n >= 3 * w + 3 && emitted < total) begin
      o = emitted;
      orow = o / w;
      ocol = o % w;
      corner = 0;
      if (orow >= 2 && orow + 3 <= h && ocol >= 2 && ocol + 3 <= w) begin
        sxx = 0;
        syy = 0;
        sxy = 0;
        for (int a = -2; a <= 2; a++) begin
          for (int b = -2; b <= 2; b++) begin
            d = 2 * w + 2 - a * w - b;
            sxx += grad_xx[(prod_wr + PROD_D - d) % PROD_D];
            syy += grad_yy[(prod_wr + PROD_D - d) % PROD_D];
            sxy += grad_xy[(prod_wr + PROD_D - d) % PROD_D];
          end
        end
        det = sxx * syy - sxy * sxy;
        if (det < 0) det = 0;
        t = (sxx + syy) * (sxx + syy);
        lhs = 128'(det) << 16;
        rhs = 128'(t) * 128'(k_reg) + 128'(thr_reg);
        corner = lhs > rhs;
      end
      r.mark = corner ? MARK_CORNER : MARK_PLAIN;
      r.is_corner = corner;
      r.last = (o == total - 1);
      marks_due.push_back(r);
      emitted++;
    end
    pix_wr = (pix_wr + 1) % PIX_D;
    prod_wr = (prod_wr + 1) % PROD_D;
    if (n >= 3 * w + 3 && emitted >= total && o == total - 1) begin
      restart_frame();
    end else begin
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      width_reg = WIDTH_RST;
      height_reg = HEIGHT_RST;
      k_reg = K_RST;
      thr_reg = THR_RST;
      for (int i = 0; i < PIX_D; i++) line_pix[i] = '0;
      for (int i = 0; i < PROD_D; i++) begin
        grad_xx[i] = 0;
        grad_yy[i] = 0;
        grad_xy[i] = 0;
      end
      pix_wr = 0;
      prod_wr = 0;
      restart_frame();
      marks_due.delete();
      fails <= 0;
      results <= 0;
      corners <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            width_reg = cfg_data[10:0];
            restart_frame();
          end
          REG_IMAGE_HEIGHT: begin
            height_reg = cfg_data[10:0];
            restart_frame();
          end
          REG_K_Q16: k_reg = cfg_data[15:0];
          REG_THRESHOLD: thr_reg = cfg_data;
          default: ;
        endcase
      end
      if (pix_valid && !pix_stall) predict_mark(pix_data);
      if (res_valid && !res_stall) begin
        results <= results + 1;
        if (res_data.is_corner) corners <= corners + 1;
        if (marks_due.size() == 0) begin
          if (fails < 10) $display("%0t: result word with none expected: %p", $time, res_data);
          fails <= fails + 1;
        end else begin
          want = marks_due.pop_front();
          if (want.mark !== res_data.mark || want.is_corner !== res_data.is_corner ||
              want.last !== res_data.last) begin
            if (fails < 10)
              $display("%0t: mismatch exp mark=%0d corner=%0d last=%0d got mark=%0d corner=%0d last=%0d",
                       $time, want.mark, want.is_corner, want.last,
                       res_data.mark, res_data.is_corner, res_data.last);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

// ----- dv/tb.sv -----
// Testbench top for harris_corner_mask: clock, reset, config writes and pixel
// frames with random gaps and stalls. Uses hcm_pkg, hcm_checker and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                         clk = 0;
  logic                         rst = 1;
  logic                         cfg_we = 0;
  logic [hcm_pkg::CFG_IW-1:0]   cfg_index = '0;
  logic [hcm_pkg::CFG_DW-1:0]   cfg_data = '0;
  logic                         pix_valid = 0;
  logic                         pix_stall;
  hcm_pkg::pix_t                pix_data = '0;
  logic                         res_valid;
  logic                         res_stall = 0;
  hcm_pkg::res_t                res_data;
  int                           fails, pending, results, corners;
  int                           words_sent = 0, frames = 0, cycles = 0, stall_left = 0;
  bit                           quiet = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  harris_corner_mask uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix_data(pix_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
  );

  hcm_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix_data(pix_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .fails(fails), .pending(pending), .results(results), .corners(corners)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("[harris_corner_mask] ERROR");
      $finish;
    end
  end

  // receiver stall: mostly short, a few long, none while quiet
  always @(posedge clk) begin
    int r;
    if (rst || quiet) begin
      res_stall <= 0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        res_stall <= 0;
        stall_left = $urandom_range(0, 3);
      end else if (r < 95) begin
        res_stall <= 1;
        stall_left = $urandom_range(0, 3);
      end else begin
        res_stall <= 1;
        stall_left = $urandom_range(20, 60);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(logic [7:0] px, logic dr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1;
    pix_data <= '{pixel: px, drain: dr};
    forever begin
      @(negedge clk);
      if (!pix_stall) begin
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
    words_sent++;
  endtask

  task automatic write_reg(logic [hcm_pkg::CFG_IW-1:0] idx, logic [hcm_pkg::CFG_DW-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic settle();
    pix_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // a dropped or no-result word may still be in flight
    repeat (100) @(posedge clk);
  endtask

  // mode: 0 random, 1 flat, 2 checker blocks, 3 extremes only
  task automatic run_frame(int w, int h, int mode);
    int bs;
    logic [7:0] lo, hi, px;
    bs = $urandom_range(1, 4);
    lo = 8'($urandom);
    hi = 8'($urandom);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 19) == 0) send_word(8'($urandom), 1'b1);
      case (mode)
        0: px = 8'($urandom);
        1: px = lo;
        2: px = ((((i / w) / bs) + ((i % w) / bs)) % 2) ? hi : lo;
        default: px = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      endcase
      send_word(px, 1'b0);
    end
    // tail: anything past the last pixel flushes
    for (int i = 0; i < 3 * w + 3; i++) send_word(8'($urandom), 1'($urandom_range(0, 1)));
    frames++;
    settle();
  endtask

  initial begin
    int w, h;
    logic [47:0] thr;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // out-of-range register index, then clamped-low geometry
    write_reg(4'd7, 48'hFFFF_FFFF_FFFF);
    write_reg(hcm_pkg::REG_IMAGE_WIDTH, 48'd0);
    write_reg(hcm_pkg::REG_IMAGE_HEIGHT, 48'd3);
    write_reg(hcm_pkg::REG_K_Q16, 48'd0);
    write_reg(hcm_pkg::REG_THRESHOLD, 48'd0);
    run_frame(5, 5, 3);
    while (words_sent < 900) begin
      w = $urandom_range(5, 12);
      h = $urandom_range(5, 10);
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 4))
        0: thr = 48'd0;
        1: thr = 48'hFFFF_FFFF_FFFF;
        2: thr = hcm_pkg::THR_RST;
        3: thr = 48'({$urandom, $urandom});
        default: thr = 48'($urandom_range(0, 1 << 24));
      endcase
      write_reg(hcm_pkg::REG_IMAGE_WIDTH, 48'(w));
      write_reg(hcm_pkg::REG_IMAGE_HEIGHT, 48'(h));
      case ($urandom_range(0, 3))
        0: write_reg(hcm_pkg::REG_K_Q16, 48'd0);
        1: write_reg(hcm_pkg::REG_K_Q16, 48'd65535);
        2: write_reg(hcm_pkg::REG_K_Q16, 48'(hcm_pkg::K_RST));
        default: write_reg(hcm_pkg::REG_K_Q16, 48'($urandom_range(0, 65535)));
      endcase
      write_reg(hcm_pkg::REG_THRESHOLD, thr);
      run_frame(w, h, $urandom_range(0, 3));
    end
    // widest geometry: width clamps down to the maximum, height clamps up;
    // only the head of that frame goes in
    quiet = 0;
    write_reg(4'd15, 48'd1);
    write_reg(hcm_pkg::REG_IMAGE_WIDTH, 48'd2047);
    write_reg(hcm_pkg::REG_IMAGE_HEIGHT, 48'd0);
    write_reg(hcm_pkg::REG_K_Q16, 48'(hcm_pkg::K_RST));
    write_reg(hcm_pkg::REG_THRESHOLD, hcm_pkg::THR_RST);
    for (int i = 0; i < 150; i++) send_word(8'($urandom), 1'b0);
    settle();
    // geometry write abandons the wide frame, a small one follows
    write_reg(hcm_pkg::REG_IMAGE_WIDTH, 48'd6);
    write_reg(hcm_pkg::REG_IMAGE_HEIGHT, 48'd6);
    run_frame(6, 6, 0);
    $display("covered %0d frames plus an abandoned wide one, %0d input words, %0d results (%0d corners)",
             frames, words_sent, results, corners);
    if (fails == 0) begin
      $display("[harris_corner_mask] OK");
    end else begin
      $display("%0d mismatches", fails);
      $display("[harris_corner_mask] ERROR");
    end
    $finish;
  end
endmodule

// ----- files.f -----
src/hcm_pkg.sv
src/hcm_ram.sv
src/hcm_ctrl.sv
src/hcm_dp.sv
src/harris_corner_mask.sv
dv/hcm_checker.sv
dv/tb.sv
